// ----- rtl/tks_pkg.sv -----
// tks_pkg: shared types and constants for the topological sort block
// used by tks_engine, tks_out and topo_sort_kahn; no dependencies
package tks_pkg;

	// fixed widths of the stream fields
	localparam int NODE_W = 6;
	localparam int CFG_W  = 7;

	// one result beat as it leaves the engine
	typedef struct packed {
		logic [NODE_W-1:0] vertex;
		logic              has_vertex;
		logic              last;
		logic              incomplete;
		logic              edges_dropped;
	} res_t;

endpackage

// ----- rtl/topo_sort_kahn.sv -----
// Kahn topological sort over a graph loaded one edge per beat.
// Slave stream: each beat may carry one edge (tuser = has_edge); tlast
// (last_edge) ends the edge list and starts the sort of the stored graph.
// A beat whose edge is stored stalls the slave side while the edge is linked in (S_LD); other beats do not.
// Master stream: one beat per vertex in topological order; tlast marks the
// final beat, which also carries the cycle and dropped-edge flags. An empty
// result gives a single beat with has_vertex low.
// The sort walks the single-port memories in steps: clear the in-degrees,
// count the in-degrees over the stored edges, seed the queue with the
// vertices of in-degree zero, walk the queue, then check for the empty
// queue and send the final beat.
// cfg channel writes node_count (reset 64), always accepted; write it
// only while idle.
// Reset empties the edge store and all lists.
// A stalled master side holds the walk until the output register frees;
// the slave side is not ready while a sort runs.
// depends on tks_pkg, tks_engine, tks_out
module topo_sort_kahn
	import tks_pkg::*;
#(
	parameter int MAX_NODES = 64,
	parameter int MAX_EDGES = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [15:0]      s_tdata,  // [5:0] src_node, [11:6] dst_node, [15:12] zero
	input  logic             s_tuser,  // [0] has_edge
	input  logic             s_tlast,  // last_edge
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata,  // [5:0] vertex, [7:6] zero
	output logic [2:0]       m_tuser,  // [0] has_vertex, [1] incomplete, [2] edges_dropped
	output logic             m_tlast
);

	logic [CFG_W-1:0] node_count_q;
	logic             push, out_free;
	res_t             res;

	// node count register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= CFG_W'(64);
		end else if (cfg_valid) begin
			node_count_q <= cfg_data;
		end
	end

	tks_engine #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_engine (
		.clk, .arst_n,
		.node_count(node_count_q),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.src_node(s_tdata[5:0]), .dst_node(s_tdata[11:6]),
		.has_edge(s_tuser), .last_edge(s_tlast),
		.out_free, .push, .res
	);

	tks_out u_out (
		.clk, .arst_n, .push, .res, .out_free,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
	);

endmodule

// ----- rtl/tks_ram.sv -----
// tks_ram: generic single-write, single-read synchronous ram
// registered read data; no dependencies
module tks_ram #(
	parameter int W = 8,
	parameter int D = 64,
	localparam int AW = (D > 1) ? $clog2(D) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [D];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/tks_engine.sv -----
// tks_engine: edge loading, in-degree count and kahn queue walk
// depends on tks_pkg and tks_ram
module tks_engine
	import tks_pkg::*;
#(
	parameter int MAX_NODES = 64,
	parameter int MAX_EDGES = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [CFG_W-1:0]  node_count,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [NODE_W-1:0] src_node,
	input  logic [NODE_W-1:0] dst_node,
	input  logic              has_edge,
	input  logic              last_edge,
	input  logic              out_free,
	output logic              push,
	output res_t              res
);

	localparam int NW  = $clog2(MAX_NODES);
	localparam int CW  = $clog2(MAX_NODES + 1);
	localparam int EIW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int LW  = $clog2(MAX_EDGES + 1);
	localparam logic [LW-1:0] LIST_END = LW'(MAX_EDGES);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_LD   = 4'd1;
	localparam logic [3:0] S_CLR  = 4'd2;
	localparam logic [3:0] S_C0   = 4'd3;
	localparam logic [3:0] S_C1   = 4'd4;
	localparam logic [3:0] S_C2   = 4'd5;
	localparam logic [3:0] S_C3   = 4'd6;
	localparam logic [3:0] S_S0   = 4'd7;
	localparam logic [3:0] S_S1   = 4'd8;
	localparam logic [3:0] S_M0   = 4'd9;
	localparam logic [3:0] S_M1   = 4'd10;
	localparam logic [3:0] S_M2   = 4'd11;
	localparam logic [3:0] S_M3   = 4'd12;
	localparam logic [3:0] S_M4   = 4'd13;
	localparam logic [3:0] S_FIN  = 4'd14;

	logic [3:0]           state_q;
	logic [CW-1:0]        u_q, wp_q, rp_q, emit_q;
	logic [NW-1:0]        v_q, src_q, held_q;
	logic [LW-1:0]        lnk_q, cnt_q;
	logic                 last_q, drop_q, held_v_q;
	logic [MAX_NODES-1:0] hv_q;

	logic [CW-1:0]  n_eff;
	logic [NW-1:0]  u_i;
	logic           u_last, in_fire, edge_ok, v_in, walk_end;
	logic [LW-1:0]  walk_lnk;
	logic [EIW-1:0] eidx;

	logic           tgt_we, tgt_re, lnk_we, lnk_re, ht_we, ht_re;
	logic           deg_we, deg_re, que_we, que_re;
	logic [EIW-1:0] tgt_wa, tgt_ra, lnk_wa, lnk_ra;
	logic [NW-1:0]  tgt_wd, tgt_rd, ht_wa, ht_ra, deg_wa, deg_ra, que_wa, que_ra;
	logic [NW-1:0]  que_wd, que_rd;
	logic [LW-1:0]  lnk_wd, lnk_rd, deg_wd, deg_rd;
	logic [2*EIW-1:0] ht_wd, ht_rd;

	// edge targets, edge links, list head/tail, in-degrees, ready queue
	tks_ram #(.W(NW), .D(MAX_EDGES)) u_tgt (
		.clk, .we(tgt_we), .waddr(tgt_wa), .wdata(tgt_wd),
		.re(tgt_re), .raddr(tgt_ra), .rdata(tgt_rd));
	tks_ram #(.W(LW), .D(MAX_EDGES)) u_lnk (
		.clk, .we(lnk_we), .waddr(lnk_wa), .wdata(lnk_wd),
		.re(lnk_re), .raddr(lnk_ra), .rdata(lnk_rd));
	tks_ram #(.W(2*EIW), .D(MAX_NODES)) u_ht (
		.clk, .we(ht_we), .waddr(ht_wa), .wdata(ht_wd),
		.re(ht_re), .raddr(ht_ra), .rdata(ht_rd));
	tks_ram #(.W(LW), .D(MAX_NODES)) u_deg (
		.clk, .we(deg_we), .waddr(deg_wa), .wdata(deg_wd),
		.re(deg_re), .raddr(deg_ra), .rdata(deg_rd));
	tks_ram #(.W(NW), .D(MAX_NODES)) u_que (
		.clk, .we(que_we), .waddr(que_wa), .wdata(que_wd),
		.re(que_re), .raddr(que_ra), .rdata(que_rd));

	// effective vertex count and shared decode
	always_comb begin
		if (node_count == '0) begin
			n_eff = CW'(1);
		end else if (32'(node_count) > MAX_NODES) begin
			n_eff = CW'(MAX_NODES);
		end else begin
			n_eff = CW'(node_count);
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign u_i      = u_q[NW-1:0];
	assign u_last   = (u_q == n_eff - CW'(1));
	assign eidx     = cnt_q[EIW-1:0];
	assign edge_ok  = has_edge && (32'(src_node) < 32'(n_eff))
	               && (32'(dst_node) < 32'(n_eff)) && (cnt_q < LIST_END);
	assign walk_lnk = (state_q == S_C2 || state_q == S_M3) ? lnk_rd : lnk_q;
	assign walk_end = (walk_lnk == LIST_END);
	assign v_in     = (CW'(tgt_rd) < n_eff);

	// memory control and result beat
	always_comb begin
		tgt_we = 1'b0; tgt_wa = '0; tgt_wd = '0; tgt_re = 1'b0; tgt_ra = '0;
		lnk_we = 1'b0; lnk_wa = '0; lnk_wd = '0; lnk_re = 1'b0; lnk_ra = '0;
		ht_we  = 1'b0; ht_wa  = '0; ht_wd  = '0; ht_re  = 1'b0; ht_ra  = '0;
		deg_we = 1'b0; deg_wa = '0; deg_wd = '0; deg_re = 1'b0; deg_ra = '0;
		que_we = 1'b0; que_wa = '0; que_wd = '0; que_re = 1'b0; que_ra = '0;
		push = 1'b0;
		res  = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire && edge_ok) begin
					tgt_we = 1'b1; tgt_wa = eidx; tgt_wd = NW'(dst_node);
					lnk_we = 1'b1; lnk_wa = eidx; lnk_wd = LIST_END;
					ht_re  = 1'b1; ht_ra  = NW'(src_node);
				end
			end
			S_LD: begin
				ht_we = 1'b1;
				ht_wa = src_q;
				ht_wd = {hv_q[src_q] ? ht_rd[2*EIW-1:EIW] : eidx, eidx};
				if (hv_q[src_q]) begin
					lnk_we = 1'b1; lnk_wa = ht_rd[EIW-1:0]; lnk_wd = cnt_q;
				end
			end
			S_CLR: begin
				deg_we = 1'b1; deg_wa = u_i; deg_wd = '0;
			end
			S_C0: begin
				if (hv_q[u_i]) begin
					ht_re = 1'b1; ht_ra = u_i;
				end
			end
			S_C1, S_M2: begin
				tgt_re = 1'b1; tgt_ra = ht_rd[2*EIW-1:EIW];
				lnk_re = 1'b1; lnk_ra = ht_rd[2*EIW-1:EIW];
			end
			S_C2, S_M3: begin
				if (v_in) begin
					deg_re = 1'b1; deg_ra = tgt_rd;
				end else if (!walk_end) begin
					tgt_re = 1'b1; tgt_ra = walk_lnk[EIW-1:0];
					lnk_re = 1'b1; lnk_ra = walk_lnk[EIW-1:0];
				end
			end
			S_C3: begin
				deg_we = 1'b1; deg_wa = v_q; deg_wd = deg_rd + LW'(1);
				if (!walk_end) begin
					tgt_re = 1'b1; tgt_ra = walk_lnk[EIW-1:0];
					lnk_re = 1'b1; lnk_ra = walk_lnk[EIW-1:0];
				end
			end
			S_S0: begin
				deg_re = 1'b1; deg_ra = u_i;
			end
			S_S1: begin
				if (deg_rd == '0) begin
					que_we = 1'b1; que_wa = wp_q[NW-1:0]; que_wd = u_i;
				end
			end
			S_M0: begin
				if (rp_q < wp_q) begin
					que_re = 1'b1; que_ra = rp_q[NW-1:0];
				end
			end
			S_M1: begin
				if (!held_v_q || out_free) begin
					push = held_v_q;
					res.vertex = NODE_W'(32'(held_q));
					res.has_vertex = 1'b1;
					if (hv_q[que_rd]) begin
						ht_re = 1'b1; ht_ra = que_rd;
					end
				end
			end
			S_M4: begin
				if (deg_rd != '0) begin
					deg_we = 1'b1; deg_wa = v_q; deg_wd = deg_rd - LW'(1);
					if (deg_rd == LW'(1) && 32'(wp_q) < MAX_NODES) begin
						que_we = 1'b1; que_wa = wp_q[NW-1:0]; que_wd = v_q;
					end
				end
				if (!walk_end) begin
					tgt_re = 1'b1; tgt_ra = walk_lnk[EIW-1:0];
					lnk_re = 1'b1; lnk_ra = walk_lnk[EIW-1:0];
				end
			end
			S_FIN: begin
				if (out_free) begin
					push = 1'b1;
					res.vertex = held_v_q ? NODE_W'(32'(held_q)) : '0;
					res.has_vertex = held_v_q;
					res.last = 1'b1;
					res.incomplete = held_v_q ? (emit_q < n_eff) : 1'b1;
					res.edges_dropped = drop_q;
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			u_q      <= '0;
			wp_q     <= '0;
			rp_q     <= '0;
			emit_q   <= '0;
			cnt_q    <= '0;
			drop_q   <= 1'b0;
			held_v_q <= 1'b0;
			hv_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (has_edge && !edge_ok) begin
							drop_q <= 1'b1;
						end
						if (edge_ok) begin
							state_q <= S_LD;
						end else if (last_edge) begin
							u_q     <= '0;
							state_q <= S_CLR;
						end
					end
				end
				S_LD: begin
					hv_q[src_q] <= 1'b1;
					cnt_q       <= cnt_q + LW'(1);
					u_q         <= '0;
					state_q     <= last_q ? S_CLR : S_IDLE;
				end
				S_CLR: begin
					u_q     <= u_last ? '0 : u_q + CW'(1);
					state_q <= u_last ? S_C0 : S_CLR;
				end
				S_C0: begin
					if (hv_q[u_i]) begin
						state_q <= S_C1;
					end else begin
						u_q     <= u_last ? '0 : u_q + CW'(1);
						state_q <= u_last ? S_S0 : S_C0;
					end
				end
				S_C1: state_q <= S_C2;
				S_C2, S_C3: begin
					if (state_q == S_C2 && v_in) begin
						state_q <= S_C3;
					end else if (walk_end) begin
						u_q     <= u_last ? '0 : u_q + CW'(1);
						state_q <= u_last ? S_S0 : S_C0;
					end else begin
						state_q <= S_C2;
					end
				end
				S_S0: state_q <= S_S1;
				S_S1: begin
					if (deg_rd == '0) begin
						wp_q <= wp_q + CW'(1);
					end
					u_q     <= u_last ? '0 : u_q + CW'(1);
					state_q <= u_last ? S_M0 : S_S0;
				end
				S_M0: begin
					if (rp_q < wp_q) begin
						rp_q    <= rp_q + CW'(1);
						state_q <= S_M1;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_M1: begin
					if (!held_v_q || out_free) begin
						held_v_q <= 1'b1;
						emit_q   <= emit_q + CW'(1);
						state_q  <= hv_q[que_rd] ? S_M2 : S_M0;
					end
				end
				S_M2: state_q <= S_M3;
				S_M3, S_M4: begin
					if (state_q == S_M4 && deg_rd == LW'(1) && 32'(wp_q) < MAX_NODES) begin
						wp_q <= wp_q + CW'(1);
					end
					if (state_q == S_M3 && v_in) begin
						state_q <= S_M4;
					end else begin
						state_q <= walk_end ? S_M0 : S_M3;
					end
				end
				S_FIN: begin
					if (out_free) begin
						hv_q     <= '0;
						cnt_q    <= '0;
						drop_q   <= 1'b0;
						held_v_q <= 1'b0;
						emit_q   <= '0;
						wp_q     <= '0;
						rp_q     <= '0;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			src_q  <= NW'(src_node);
			last_q <= last_edge;
		end
		if (state_q == S_C2 || state_q == S_M3) begin
			v_q   <= tgt_rd;
			lnk_q <= lnk_rd;
		end
		if (state_q == S_M1 && (!held_v_q || out_free)) begin
			held_q <= que_rd;
		end
	end

	// a beat is only pushed into a free output register
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> out_free)
		else $error("result pushed into a full output register");

	// queue pointers stay ordered and bounded by MAX_NODES
	a_ptr_order: assert property (@(posedge clk) disable iff (!arst_n)
		(rp_q <= wp_q) && (wp_q <= CW'(MAX_NODES)))
		else $error("ready queue pointers out of order");

	// the final beat of a sort returns the block to idle with empty lists
	a_fin_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && out_free) |=> (state_q == S_IDLE && hv_q == '0 && cnt_q == '0))
		else $error("edge store not cleared after sort");

endmodule

// ----- rtl/tks_out.sv -----
// tks_out: output register between the engine and the master stream
// depends on tks_pkg
module tks_out
	import tks_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  res_t              res,
	output logic              out_free,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,  // [5:0] vertex, [7:6] zero
	output logic [2:0]        m_tuser,  // [0] has_vertex, [1] incomplete, [2] edges_dropped
	output logic              m_tlast
);

	logic valid_q;
	res_t res_q;

	assign out_free = !valid_q || m_tready;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	// beat payload
	always_ff @(posedge clk) begin
		if (push) begin
			res_q <= res;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {2'b00, res_q.vertex};
	assign m_tuser  = {res_q.edges_dropped, res_q.incomplete, res_q.has_vertex};
	assign m_tlast  = res_q.last;

endmodule
